/* rtl/core/lbpc_pkg.sv */
package lbpc_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned COORD_BITS_DEF   = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ATAN_TAB_LEN     = 24;

  // Angle constants in 1/64 degree
  localparam int DEG90_64  = 5760;
  localparam int DEG180_64 = 11520;
  localparam int DEG360_64 = 23040;

  // Angle constants in 1/128 degree
  localparam int DEG90_128  = 11520;
  localparam int DEG180_128 = 23040;
  localparam int DEG360_128 = 46080;

  // Configuration register indexes
  localparam logic [2:0] CFG_HEIGHT_RATIO_MIN   = 3'd0;
  localparam logic [2:0] CFG_HEIGHT_RATIO_MAX   = 3'd1;
  localparam logic [2:0] CFG_DIRECTION_DIFF_MAX = 3'd2;
  localparam logic [2:0] CFG_SPACING_RATIO_MIN  = 3'd3;
  localparam logic [2:0] CFG_SPACING_RATIO_MAX  = 3'd4;
  localparam logic [2:0] CFG_ALIGNMENT_DEV_MAX  = 3'd5;

  // Reset values of the configuration registers
  localparam logic [11:0] RST_HEIGHT_RATIO_MIN   = 12'd172;
  localparam logic [11:0] RST_HEIGHT_RATIO_MAX   = 12'd384;
  localparam logic [13:0] RST_DIRECTION_DIFF_MAX = 14'd960;
  localparam logic [11:0] RST_SPACING_RATIO_MIN  = 12'd384;
  localparam logic [11:0] RST_SPACING_RATIO_MAX  = 12'd1024;
  localparam logic [13:0] RST_ALIGNMENT_DEV_MAX  = 14'd1280;

  // Reject codes
  localparam logic [2:0] REJ_NONE      = 3'd0;
  localparam logic [2:0] REJ_HEIGHT    = 3'd1;
  localparam logic [2:0] REJ_DIRECTION = 3'd2;
  localparam logic [2:0] REJ_SPACING   = 3'd3;
  localparam logic [2:0] REJ_ALIGNMENT = 3'd4;
  localparam logic [2:0] REJ_ZERO      = 3'd5;

  // CORDIC angle accumulator width (1/32768 degree)
  localparam int unsigned ZW = 24;

  typedef struct packed {
    logic [11:0] height_ratio_min;
    logic [11:0] height_ratio_max;
    logic [13:0] direction_diff_max;
    logic [11:0] spacing_ratio_min;
    logic [11:0] spacing_ratio_max;
    logic [13:0] alignment_dev_max;
  } cfg_t;

  // Test results and angles that ride beside the CORDIC data
  typedef struct packed {
    logic               zero_fail;
    logic               ratio_fail;
    logic               dir_fail;
    logic               space_fail;
    logic signed [16:0] dir_sum;   // sum of both bar directions, 1/64 deg each
    logic               special;   // atan2 result is base alone
    logic signed [15:0] base;      // 1/128 deg
  } side_t;

  // atan(2^-i) in 1/32768 degree
  function automatic logic [20:0] atan_tab(input int unsigned i);
    logic [20:0] r;
    case (i)
      0: r = 21'd1474560;
      1: r = 21'd870484;
      2: r = 21'd459940;
      3: r = 21'd233473;
      4: r = 21'd117189;
      5: r = 21'd58652;
      6: r = 21'd29333;
      7: r = 21'd14667;
      8: r = 21'd7334;
      9: r = 21'd3667;
      10: r = 21'd1833;
      11: r = 21'd917;
      12: r = 21'd458;
      13: r = 21'd229;
      14: r = 21'd115;
      15: r = 21'd57;
      16: r = 21'd29;
      17: r = 21'd14;
      18: r = 21'd7;
      19: r = 21'd4;
      20: r = 21'd2;
      21: r = 21'd1;
      default: r = 21'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/light_bar_pair_check_top.sv */
// Channel  Handshake                   Word
// in       in_valid_i / in_ready_o     first_* and second_* bar fields
// out      out_valid_o / out_ready_i   pair_ok_o, reject_code_o
// cfg      cfg_we_i                    cfg_index_i, cfg_data_i
//
// One word enters per cycle while the output side accepts; the pipe has four front
// stages, one stage per CORDIC rotation and two result stages.
// Every stage holds its own valid bit, so a stall fills empty stages first.
// Reset clears all valid bits and loads the register defaults.
module light_bar_pair_check_top #(
  parameter int unsigned COORD_BITS   = lbpc_pkg::COORD_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = lbpc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [13:0]           cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS-1:0] first_center_x_i,
  input  logic [COORD_BITS-1:0] first_center_y_i,
  input  logic [15:0]           first_width_i,
  input  logic [15:0]           first_height_i,
  input  logic [14:0]           first_angle_i,
  input  logic [COORD_BITS-1:0] second_center_x_i,
  input  logic [COORD_BITS-1:0] second_center_y_i,
  input  logic [15:0]           second_width_i,
  input  logic [15:0]           second_height_i,
  input  logic [14:0]           second_angle_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  pair_ok_o,
  output logic [2:0]            reject_code_o
);
  import lbpc_pkg::*;

  // Configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.height_ratio_min   <= RST_HEIGHT_RATIO_MIN;
      cfg_q.height_ratio_max   <= RST_HEIGHT_RATIO_MAX;
      cfg_q.direction_diff_max <= RST_DIRECTION_DIFF_MAX;
      cfg_q.spacing_ratio_min  <= RST_SPACING_RATIO_MIN;
      cfg_q.spacing_ratio_max  <= RST_SPACING_RATIO_MAX;
      cfg_q.alignment_dev_max  <= RST_ALIGNMENT_DEV_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HEIGHT_RATIO_MIN:   cfg_q.height_ratio_min   <= cfg_data_i[11:0];
        CFG_HEIGHT_RATIO_MAX:   cfg_q.height_ratio_max   <= cfg_data_i[11:0];
        CFG_DIRECTION_DIFF_MAX: cfg_q.direction_diff_max <= cfg_data_i;
        CFG_SPACING_RATIO_MIN:  cfg_q.spacing_ratio_min  <= cfg_data_i[11:0];
        CFG_SPACING_RATIO_MAX:  cfg_q.spacing_ratio_max  <= cfg_data_i[11:0];
        CFG_ALIGNMENT_DEV_MAX:  cfg_q.alignment_dev_max  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic                          f_valid, f_ready, c_valid, c_ready;
  side_t                         f_side, c_side;
  logic signed [COORD_BITS+11:0] f_x, f_y;
  logic signed [ZW-1:0]          c_z;

  lbpc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i, .rst_ni,
    .cfg_i             (cfg_q),
    .in_valid_i, .in_ready_o,
    .first_center_x_i, .first_center_y_i, .first_width_i, .first_height_i,
    .first_angle_i,
    .second_center_x_i, .second_center_y_i, .second_width_i, .second_height_i,
    .second_angle_i,
    .out_valid_o       (f_valid),
    .out_ready_i       (f_ready),
    .side_o            (f_side),
    .x_o               (f_x),
    .y_o               (f_y)
  );

  lbpc_cordic #(.COORD_BITS(COORD_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni,
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .side_i      (f_side),
    .x_i         (f_x),
    .y_i         (f_y),
    .out_valid_o (c_valid),
    .out_ready_i (c_ready),
    .side_o      (c_side),
    .z_o         (c_z)
  );

  lbpc_back u_back (
    .clk_i, .rst_ni,
    .cfg_i       (cfg_q),
    .in_valid_i  (c_valid),
    .in_ready_o  (c_ready),
    .side_i      (c_side),
    .z_i         (c_z),
    .out_valid_o, .out_ready_i,
    .pair_ok_o, .reject_code_o
  );

endmodule

/* rtl/core/lbpc_front.sv */
module lbpc_front #(
  parameter int unsigned COORD_BITS = lbpc_pkg::COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lbpc_pkg::cfg_t          cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [COORD_BITS-1:0]   first_center_x_i,
  input  logic [COORD_BITS-1:0]   first_center_y_i,
  input  logic [15:0]             first_width_i,
  input  logic [15:0]             first_height_i,
  input  logic [14:0]             first_angle_i,
  input  logic [COORD_BITS-1:0]   second_center_x_i,
  input  logic [COORD_BITS-1:0]   second_center_y_i,
  input  logic [15:0]             second_width_i,
  input  logic [15:0]             second_height_i,
  input  logic [14:0]             second_angle_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output lbpc_pkg::side_t         side_o,
  output logic signed [COORD_BITS+11:0] x_o,
  output logic signed [COORD_BITS+11:0] y_o
);
  import lbpc_pkg::*;

  localparam int unsigned DW   = COORD_BITS + 1;
  localparam int unsigned XW   = COORD_BITS + 12;
  localparam int unsigned SQW  = 2 * COORD_BITS;
  localparam int unsigned D2W  = 2 * COORD_BITS + 1;
  localparam int unsigned S2W  = 58;
  localparam int unsigned CMPW = (D2W + 18 > S2W) ? D2W + 18 : S2W;

  // Fold a bar direction once into [-180, 180] degrees
  function automatic logic signed [14:0] fold_dir(input logic signed [15:0] d);
    logic signed [15:0] r;
    r = d;
    if (d > 16'(DEG180_64)) begin
      r = d - 16'(DEG360_64);
    end else if (d < -16'(DEG180_64)) begin
      r = d + 16'(DEG360_64);
    end
    return r[14:0];
  endfunction

  // Stage handshake
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o  = en1;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // ---------------- stage 1: products, directions, differences
  logic signed [15:0] ang_a, ang_b, dir_a, dir_b;
  logic               zero1_d;
  logic [27:0]        pmin1_d, pmax1_d;
  logic signed [14:0] fa1_d, fb1_d;
  logic signed [16:0] dsum1_d;
  logic signed [DW-1:0] dx1_d, dy1_d;
  logic [16:0]        hs1_d;

  always_comb begin
    ang_a   = {first_angle_i[14], first_angle_i};
    ang_b   = {second_angle_i[14], second_angle_i};
    dir_a   = (first_width_i >= first_height_i) ? ang_a : ang_a + 16'(DEG90_64);
    dir_b   = (second_width_i >= second_height_i) ? ang_b : ang_b + 16'(DEG90_64);
    zero1_d = (first_height_i == 16'd0) || (second_height_i == 16'd0);
    pmin1_d = 28'(cfg_i.height_ratio_min) * 28'(second_height_i);
    pmax1_d = 28'(cfg_i.height_ratio_max) * 28'(second_height_i);
    fa1_d   = fold_dir(dir_a);
    fb1_d   = fold_dir(dir_b);
    dsum1_d = {dir_a[15], dir_a} + {dir_b[15], dir_b};
    dx1_d   = $signed({1'b0, first_center_x_i}) - $signed({1'b0, second_center_x_i});
    dy1_d   = $signed({1'b0, first_center_y_i}) - $signed({1'b0, second_center_y_i});
    hs1_d   = {1'b0, first_height_i} + {1'b0, second_height_i};
  end

  logic               zero1_q;
  logic [15:0]        ah1_q;
  logic [27:0]        pmin1_q, pmax1_q;
  logic signed [14:0] fa1_q, fb1_q;
  logic signed [16:0] dsum1_q;
  logic signed [DW-1:0] dx1_q, dy1_q;
  logic [16:0]        hs1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      zero1_q <= zero1_d;
      ah1_q   <= first_height_i;
      pmin1_q <= pmin1_d;
      pmax1_q <= pmax1_d;
      fa1_q   <= fa1_d;
      fb1_q   <= fb1_d;
      dsum1_q <= dsum1_d;
      dx1_q   <= dx1_d;
      dy1_q   <= dy1_d;
      hs1_q   <= hs1_d;
    end
  end

  // ---------------- stage 2: ratio and direction tests, squares, atan2 setup
  logic [27:0]        ah256;
  logic signed [15:0] dif, adif, fdif;
  logic signed [2*DW-1:0] pxx, pyy;
  logic signed [DW-1:0] xa, ya;
  logic               ratio2_d, dir2_d, spec2_d;
  logic signed [15:0] base2_d;
  logic [SQW-1:0]     dx2_d, dy2_d;
  logic [28:0]        smin2_d, smax2_d;
  logic signed [XW-1:0] x2_d, y2_d;

  always_comb begin
    ah256    = {4'b0, ah1_q, 8'b0};
    ratio2_d = (ah256 < pmin1_q) || (ah256 > pmax1_q);
    dif      = 16'(fa1_q) - 16'(fb1_q);
    adif     = (dif < 0) ? -dif : dif;
    fdif     = (adif > 16'(DEG90_64)) ? 16'(DEG180_64) - adif : adif;
    dir2_d   = fdif > $signed({2'b0, cfg_i.direction_diff_max});
    pxx      = dx1_q * dx1_q;
    pyy      = dy1_q * dy1_q;
    dx2_d    = pxx[SQW-1:0];
    dy2_d    = pyy[SQW-1:0];
    smin2_d  = 29'(cfg_i.spacing_ratio_min) * 29'(hs1_q);
    smax2_d  = 29'(cfg_i.spacing_ratio_max) * 29'(hs1_q);
    // atan2 quadrant handling and the axis cases
    spec2_d  = 1'b0;
    base2_d  = '0;
    xa       = dx1_q;
    ya       = dy1_q;
    if (dy1_q == '0) begin
      spec2_d = 1'b1;
      base2_d = (dx1_q < 0) ? 16'(DEG180_128) : 16'sd0;
    end else if (dx1_q == '0) begin
      spec2_d = 1'b1;
      base2_d = (dy1_q > 0) ? 16'(DEG90_128) : -16'(DEG90_128);
    end else if (dx1_q < 0) begin
      base2_d = (dy1_q > 0) ? 16'(DEG180_128) : -16'(DEG180_128);
      xa      = -dx1_q;
      ya      = -dy1_q;
    end
    x2_d = XW'(xa) <<< 8;
    y2_d = XW'(ya) <<< 8;
  end

  logic               zero2_q, ratio2_q, dir2_q, spec2_q;
  logic signed [15:0] base2_q;
  logic signed [16:0] dsum2_q;
  logic [SQW-1:0]     dx2_q, dy2_q;
  logic [28:0]        smin2_q, smax2_q;
  logic signed [XW-1:0] x2_q, y2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      zero2_q  <= zero1_q;
      ratio2_q <= ratio2_d;
      dir2_q   <= dir2_d;
      spec2_q  <= spec2_d;
      base2_q  <= base2_d;
      dsum2_q  <= dsum1_q;
      dx2_q    <= dx2_d;
      dy2_q    <= dy2_d;
      smin2_q  <= smin2_d;
      smax2_q  <= smax2_d;
      x2_q     <= x2_d;
      y2_q     <= y2_d;
    end
  end

  // ---------------- stage 3: squared distance and squared bounds
  logic [D2W-1:0] d2_3_d;
  logic [S2W-1:0] s2min3_d, s2max3_d;

  always_comb begin
    d2_3_d   = D2W'(dx2_q) + D2W'(dy2_q);
    s2min3_d = S2W'(smin2_q) * S2W'(smin2_q);
    s2max3_d = S2W'(smax2_q) * S2W'(smax2_q);
  end

  logic               zero3_q, ratio3_q, dir3_q, spec3_q;
  logic signed [15:0] base3_q;
  logic signed [16:0] dsum3_q;
  logic [D2W-1:0]     d2_3_q;
  logic [S2W-1:0]     s2min3_q, s2max3_q;
  logic signed [XW-1:0] x3_q, y3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      zero3_q  <= zero2_q;
      ratio3_q <= ratio2_q;
      dir3_q   <= dir2_q;
      spec3_q  <= spec2_q;
      base3_q  <= base2_q;
      dsum3_q  <= dsum2_q;
      d2_3_q   <= d2_3_d;
      s2min3_q <= s2min3_d;
      s2max3_q <= s2max3_d;
      x3_q     <= x2_q;
      y3_q     <= y2_q;
    end
  end

  // ---------------- stage 4: spacing test, compared squared and scaled by 2^18
  logic [CMPW-1:0] d2s, lo_b, hi_b;
  logic            space4_d;

  always_comb begin
    d2s      = CMPW'({d2_3_q, 18'b0});
    lo_b     = CMPW'(s2min3_q);
    hi_b     = CMPW'(s2max3_q);
    space4_d = (d2s < lo_b) || (d2s > hi_b);
  end

  side_t              side4_q;
  logic signed [XW-1:0] x4_q, y4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      side4_q.zero_fail  <= zero3_q;
      side4_q.ratio_fail <= ratio3_q;
      side4_q.dir_fail   <= dir3_q;
      side4_q.space_fail <= space4_d;
      side4_q.dir_sum    <= dsum3_q;
      side4_q.special    <= spec3_q;
      side4_q.base       <= base3_q;
      x4_q               <= x3_q;
      y4_q               <= y3_q;
    end
  end

  assign side_o = side4_q;
  assign x_o    = x4_q;
  assign y_o    = y4_q;

endmodule

/* rtl/core/lbpc_cordic.sv */
module lbpc_cordic #(
  parameter int unsigned COORD_BITS   = lbpc_pkg::COORD_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = lbpc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lbpc_pkg::side_t               side_i,
  input  logic signed [COORD_BITS+11:0] x_i,
  input  logic signed [COORD_BITS+11:0] y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lbpc_pkg::side_t               side_o,
  output logic signed [lbpc_pkg::ZW-1:0] z_o
);
  import lbpc_pkg::*;

  localparam int unsigned XW = COORD_BITS + 12;

  logic                    v_q [CORDIC_STEPS];
  logic [CORDIC_STEPS:0]   en;
  logic [CORDIC_STEPS:0]   v_in;

  logic signed [XW-1:0] x_q [CORDIC_STEPS];
  logic signed [XW-1:0] y_q [CORDIC_STEPS];
  logic signed [ZW-1:0] z_q [CORDIC_STEPS];
  side_t                s_q [CORDIC_STEPS];

  logic signed [XW-1:0] x_in [CORDIC_STEPS];
  logic signed [XW-1:0] y_in [CORDIC_STEPS];
  logic signed [ZW-1:0] z_in [CORDIC_STEPS];
  side_t                s_in [CORDIC_STEPS];

  assign en[CORDIC_STEPS]   = out_ready_i;
  assign v_in[0]            = in_valid_i;
  assign v_in[CORDIC_STEPS] = v_q[CORDIC_STEPS-1];
  assign in_ready_o         = en[0];
  assign out_valid_o        = v_q[CORDIC_STEPS-1];
  assign side_o             = s_q[CORDIC_STEPS-1];
  assign z_o                = z_q[CORDIC_STEPS-1];

  assign x_in[0] = x_i;
  assign y_in[0] = y_i;
  assign z_in[0] = '0;
  assign s_in[0] = side_i;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XW-1:0] xs, ys, x_d, y_d;
    logic signed [ZW-1:0] z_d, a;

    if (i > 0) begin : g_link
      assign x_in[i] = x_q[i-1];
      assign y_in[i] = y_q[i-1];
      assign z_in[i] = z_q[i-1];
      assign s_in[i] = s_q[i-1];
      assign v_in[i] = v_q[i-1];
    end

    assign en[i] = !v_q[i] || en[i+1];

    // One rotation toward the x axis
    always_comb begin
      xs = x_in[i] >>> i;
      ys = y_in[i] >>> i;
      a  = $signed(ZW'(atan_tab(i)));
      if (y_in[i] >= 0) begin
        x_d = x_in[i] + ys;
        y_d = y_in[i] - xs;
        z_d = z_in[i] + a;
      end else begin
        x_d = x_in[i] - ys;
        y_d = y_in[i] + xs;
        z_d = z_in[i] - a;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en[i]) begin
        v_q[i] <= v_in[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[i]) begin
        x_q[i] <= x_d;
        y_q[i] <= y_d;
        z_q[i] <= z_d;
        s_q[i] <= s_in[i];
      end
    end
  end

endmodule

/* rtl/core/lbpc_back.sv */
module lbpc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lbpc_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lbpc_pkg::side_t               side_i,
  input  logic signed [lbpc_pkg::ZW-1:0] z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          pair_ok_o,
  output logic [2:0]                    reject_code_o
);
  import lbpc_pkg::*;

  logic va_q, vb_q, ena, enb;

  assign enb         = !vb_q || out_ready_i;
  assign ena         = !va_q || enb;
  assign in_ready_o  = ena;
  assign out_valid_o = vb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ena) va_q <= in_valid_i;
      if (enb) vb_q <= va_q;
    end
  end

  // Stage A: round atan2 to 1/128 deg, take the wrapped angle difference
  logic signed [ZW-1:0] zr;
  logic signed [16:0]   c;
  logic signed [18:0]   diff, diff_a_d;

  always_comb begin
    zr   = (z_i + ZW'(128)) >>> 8;
    c    = side_i.special ? 17'(side_i.base) : 17'(side_i.base) + zr[16:0];
    diff = 19'(side_i.dir_sum) - 19'(c);
    diff_a_d = diff;
    if (diff > 19'(DEG180_128)) begin
      diff_a_d = diff - 19'(DEG360_128);
    end else if (diff < -19'(DEG180_128)) begin
      diff_a_d = diff + 19'(DEG360_128);
    end
  end

  side_t              side_a_q;
  logic signed [18:0] diff_a_q;

  always_ff @(posedge clk_i) begin
    if (ena) begin
      side_a_q <= side_i;
      diff_a_q <= diff_a_d;
    end
  end

  // Stage B: deviation from perpendicular, then pick the first failed test
  logic signed [18:0] adiff, dev, adev;
  logic               align_fail;
  logic [2:0]         code_d;

  always_comb begin
    adiff      = (diff_a_q < 0) ? -diff_a_q : diff_a_q;
    dev        = adiff - 19'(DEG90_128);
    adev       = (dev < 0) ? -dev : dev;
    align_fail = adev > $signed({4'b0, cfg_i.alignment_dev_max, 1'b0});
    if (side_a_q.zero_fail) begin
      code_d = REJ_ZERO;
    end else if (side_a_q.ratio_fail) begin
      code_d = REJ_HEIGHT;
    end else if (side_a_q.dir_fail) begin
      code_d = REJ_DIRECTION;
    end else if (side_a_q.space_fail) begin
      code_d = REJ_SPACING;
    end else if (align_fail) begin
      code_d = REJ_ALIGNMENT;
    end else begin
      code_d = REJ_NONE;
    end
  end

  logic [2:0] code_q;

  always_ff @(posedge clk_i) begin
    if (enb) begin
      code_q <= code_d;
    end
  end

  assign reject_code_o = code_q;
  assign pair_ok_o     = (code_q == REJ_NONE);

endmodule

/* rtl/core/lbpc_checker.sv */
module lbpc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       pair_ok_o,
  input logic [2:0] reject_code_o
);
  import lbpc_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(reject_code_o))
    else $error("stalled result changed");

  // Accept flag agrees with the code
  a_ok_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pair_ok_o == (reject_code_o == REJ_NONE)))
    else $error("pair_ok disagrees with reject_code");

  // Only defined codes leave the block
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reject_code_o <= REJ_ZERO))
    else $error("undefined reject code");

  // An empty output stage lets the whole pipe advance
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind light_bar_pair_check_top lbpc_checker u_lbpc_checker (.*);

/* test/tb_light_bar_pair_check_top.sv */
module tb_light_bar_pair_check_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lbpc_pkg::*;

  localparam int LATENCY = CORDIC_STEPS_DEF + 6;
  localparam int STALL_LIMIT = 5000;
  localparam int N_RANDOM = 1900;

  typedef struct packed {
    logic [15:0] ax, ay, aw, ah;
    logic [14:0] aang;
    logic [15:0] bx, by, bw, bh;
    logic [14:0] bang;
  } bar_pair_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] code;
  } verdict_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_index_i;
  logic [13:0] cfg_data_i;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  bar_pair_t in_word;
  logic pair_ok_o;
  logic [2:0] reject_code_o;

  light_bar_pair_check_top u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .first_center_x_i(in_word.ax), .first_center_y_i(in_word.ay),
    .first_width_i(in_word.aw), .first_height_i(in_word.ah),
    .first_angle_i(in_word.aang),
    .second_center_x_i(in_word.bx), .second_center_y_i(in_word.by),
    .second_width_i(in_word.bw), .second_height_i(in_word.bh),
    .second_angle_i(in_word.bang),
    .out_valid_o, .out_ready_i, .pair_ok_o, .reject_code_o
  );

  // Shadow copy of the thresholds
  cfg_t thr;
  bar_pair_t pending_words[$];
  verdict_t expected_verdicts[$];
  int n_errors;
  int idle_cycles;
  bit calm;
  bit timed_out;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint cordic_atan2(longint y, longint x);
    longint base, z, t;
    base = 0;
    z = 0;
    if (y == 0) return (x < 0) ? DEG180_128 : 0;
    if (x == 0) return (y > 0) ? DEG90_128 : -DEG90_128;
    if (x < 0) begin
      base = (y > 0) ? DEG180_128 : -DEG180_128;
      x = -x;
      y = -y;
    end
    x = x * 256;
    y = y * 256;
    for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_TAB_LEN; i++) begin
      if (y >= 0) begin
        t = x + floor_shr(y, i);
        y = y - floor_shr(x, i);
        z = z + longint'(atan_tab(i));
      end else begin
        t = x - floor_shr(y, i);
        y = y + floor_shr(x, i);
        z = z - longint'(atan_tab(i));
      end
      x = t;
    end
    return base + floor_shr(z + 128, 8);
  endfunction

  function automatic int fold_dir(int a);
    while (a > DEG180_64) a -= DEG360_64;
    while (a < -DEG180_64) a += DEG360_64;
    return a;
  endfunction

  // Run the zero-height, height, direction, spacing and alignment tests in order and report the first that fails
  function automatic verdict_t judge_pair(bar_pair_t p);
    verdict_t v;
    int da, db, dif;
    longint dx, dy, c, diff, dev;
    longint unsigned d2, smin, smax;
    logic [2:0] code;
    da = (p.aw >= p.ah) ? int'($signed(p.aang)) : int'($signed(p.aang)) + DEG90_64;
    db = (p.bw >= p.bh) ? int'($signed(p.bang)) : int'($signed(p.bang)) + DEG90_64;
    dx = longint'(p.ax) - longint'(p.bx);
    dy = longint'(p.ay) - longint'(p.by);
    d2 = dx * dx + dy * dy;
    smin = longint'(thr.spacing_ratio_min) * (longint'(p.ah) + longint'(p.bh));
    smax = longint'(thr.spacing_ratio_max) * (longint'(p.ah) + longint'(p.bh));
    dif = fold_dir(da) - fold_dir(db);
    if (dif < 0) dif = -dif;
    if (dif > DEG90_64) dif = DEG180_64 - dif;
    if (p.ah == 0 || p.bh == 0) code = REJ_ZERO;
    else if (longint'(p.ah) * 256 < longint'(thr.height_ratio_min) * p.bh ||
             longint'(p.ah) * 256 > longint'(thr.height_ratio_max) * p.bh)
      code = REJ_HEIGHT;
    else if (dif > int'(thr.direction_diff_max)) code = REJ_DIRECTION;
    else if ((d2 >> 40) == 0 && (d2 << 18) < smin * smin) code = REJ_SPACING;
    else if ((d2 >> 40) != 0 || (d2 << 18) > smax * smax) code = REJ_SPACING;
    else begin
      c = cordic_atan2(dy, dx);
      diff = longint'(da) + longint'(db) - c;
      while (diff > DEG180_128) diff -= DEG360_128;
      while (diff < -DEG180_128) diff += DEG360_128;
      if (diff < 0) diff = -diff;
      dev = diff - DEG90_128;
      if (dev < 0) dev = -dev;
      code = (dev > 2 * longint'(thr.alignment_dev_max)) ? REJ_ALIGNMENT : REJ_NONE;
    end
    v.code = code;
    v.ok = (code == REJ_NONE);
    return v;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    n_errors++;
  endtask

  // Append a word to the pending queue
  task automatic add_word(bar_pair_t p);
    pending_words = {pending_words, p};
  endtask

  // Roll an idle decision; calm stretches never idle
  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 36);
  endfunction

  // Drive words from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_verdicts = {expected_verdicts, judge_pair(in_word)};
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() > 0 && !take_break()) begin
          in_valid_i <= 1'b1;
          in_word <= pending_words.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Check verdicts and throttle the output side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("verdict with nothing expected");
        end else begin
          verdict_t e;
          e = expected_verdicts.pop_front();
          if (pair_ok_o !== e.ok)
            report_mismatch($sformatf("pair_ok %b, want %b", pair_ok_o, e.ok));
          if (reject_code_o !== e.code)
            report_mismatch($sformatf("reject_code %0d, want %0d", reject_code_o, e.code));
        end
      end
      out_ready_i <= !take_break();
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (idle_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("tb_light_bar_pair_check_top: done, errors");
      $finish;
    end
  end

  function automatic logic [14:0] rand_angle();
    int a;
    a = $urandom_range(3) == 0 ? int'($urandom_range(32767)) - 16384
                               : int'($urandom_range(23040)) - 11520;
    return a[14:0];
  endfunction

  // Build a plausible pair around a random geometry
  function automatic bar_pair_t plausible_pair();
    bar_pair_t p;
    int h, sep, ang;
    h = $urandom_range(4000, 16);
    p.ah = h[15:0];
    p.bh = 16'(h * $urandom_range(80, 120) / 100 + $urandom_range(1));
    p.aw = $urandom_range(3) == 0 ? 16'($urandom_range(65535)) : 16'($urandom_range(h / 3));
    p.bw = $urandom_range(3) == 0 ? 16'($urandom_range(65535)) : 16'($urandom_range(h / 3));
    ang = int'($urandom_range(1280)) - 640;
    p.aang = 15'(ang);
    p.bang = 15'(ang + int'($urandom_range(200)) - 100);
    sep = h * $urandom_range(120, 450) / 100;
    p.ax = 16'($urandom_range(30000, 2000));
    p.ay = 16'($urandom_range(60000, 2000));
    p.bx = 16'(p.ax + sep);
    p.by = 16'(int'(p.ay) + int'($urandom_range(h / 2)) - h / 4);
    if ($urandom_range(1)) begin
      {p.ax, p.ay, p.aw, p.ah, p.aang, p.bx, p.by, p.bw, p.bh, p.bang} =
        {p.bx, p.by, p.bw, p.bh, p.bang, p.ax, p.ay, p.aw, p.ah, p.aang};
    end
    return p;
  endfunction

  function automatic bar_pair_t noise_pair();
    bar_pair_t p;
    p.ax = 16'($urandom); p.ay = 16'($urandom); p.aw = 16'($urandom);
    p.ah = $urandom_range(15) == 0 ? 16'd0 : 16'($urandom);
    p.aang = rand_angle();
    p.bx = 16'($urandom); p.by = 16'($urandom); p.bw = 16'($urandom);
    p.bh = $urandom_range(15) == 0 ? 16'd0 : 16'($urandom);
    p.bang = rand_angle();
    return p;
  endfunction

  task automatic write_threshold(logic [2:0] idx, logic [13:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_HEIGHT_RATIO_MIN:   thr.height_ratio_min = val[11:0];
      CFG_HEIGHT_RATIO_MAX:   thr.height_ratio_max = val[11:0];
      CFG_DIRECTION_DIFF_MAX: thr.direction_diff_max = val;
      CFG_SPACING_RATIO_MIN:  thr.spacing_ratio_min = val[11:0];
      CFG_SPACING_RATIO_MAX:  thr.spacing_ratio_max = val[11:0];
      CFG_ALIGNMENT_DEV_MAX:  thr.alignment_dev_max = val;
      default: ;
    endcase
  endtask

  // Sample away from the rising edge so queue and valid updates have settled
  task automatic drain();
    while (pending_words.size() > 0 || in_valid_i || expected_verdicts.size() > 0)
      @(negedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic queue_directed();
    bar_pair_t p;
    p = plausible_pair();
    add_word(p);
    p.ah = 0; add_word(p);
    p = plausible_pair(); p.bh = 0; add_word(p);
    p = plausible_pair(); p.ah = 16'hFFFF; p.bh = 16'd1; add_word(p);
    p = plausible_pair(); p.ah = 16'd1; p.bh = 16'hFFFF; add_word(p);
    p = plausible_pair(); p.aang = 15'sd11520; p.bang = -15'sd11520;
    add_word(p);
    p = plausible_pair(); p.aang = 15'h3FFF; p.bang = 15'h4000; add_word(p);
    p = plausible_pair(); p.bx = p.ax; p.by = p.ay; add_word(p);
    p = plausible_pair(); p.by = p.ay; p.bx = p.ax - 16'd500; add_word(p);
    p = plausible_pair(); p.bx = p.ax; p.by = p.ay + 16'd300; add_word(p);
    p = plausible_pair(); p.bx = p.ax; p.by = p.ay - 16'd300; add_word(p);
    p = plausible_pair(); p.ax = 0; p.ay = 0; p.bx = 16'hFFFF; p.by = 16'hFFFF;
    add_word(p);
    p = plausible_pair(); p.aw = 16'hFFFF; p.bw = 16'hFFFF; p.aang = 15'd5760;
    add_word(p);
    p = '1; add_word(p);
    p = plausible_pair(); p.aw = p.ah; add_word(p);
    p = plausible_pair(); p.bx = p.ax - 16'd1; p.by = p.ay - 16'd1000;
    add_word(p);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++)
      add_word($urandom_range(3) == 0 ? noise_pair() : plausible_pair());
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    n_errors = 0;
    calm = 1'b0;
    timed_out = 1'b0;
    thr = '{RST_HEIGHT_RATIO_MIN, RST_HEIGHT_RATIO_MAX, RST_DIRECTION_DIFF_MAX,
            RST_SPACING_RATIO_MIN, RST_SPACING_RATIO_MAX, RST_ALIGNMENT_DEV_MAX};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Defaults first
    queue_directed();
    queue_random(N_RANDOM / 4);
    drain();

    // Wide-open thresholds, no idling
    calm = 1'b1;
    write_threshold(CFG_HEIGHT_RATIO_MIN, 14'd0);
    write_threshold(CFG_HEIGHT_RATIO_MAX, 14'hFFF);
    write_threshold(CFG_DIRECTION_DIFF_MAX, 14'd11520);
    write_threshold(CFG_SPACING_RATIO_MIN, 14'd0);
    write_threshold(CFG_SPACING_RATIO_MAX, 14'hFFF);
    write_threshold(CFG_ALIGNMENT_DEV_MAX, 14'h3FFF);
    write_threshold(3'd7, 14'd5);
    queue_directed();
    queue_random(N_RANDOM / 4);
    drain();
    calm = 1'b0;

    // Tightest thresholds
    write_threshold(CFG_HEIGHT_RATIO_MIN, 14'hFFF);
    write_threshold(CFG_HEIGHT_RATIO_MAX, 14'd0);
    write_threshold(CFG_DIRECTION_DIFF_MAX, 14'd0);
    write_threshold(CFG_SPACING_RATIO_MIN, 14'hFFF);
    write_threshold(CFG_SPACING_RATIO_MAX, 14'd0);
    write_threshold(CFG_ALIGNMENT_DEV_MAX, 14'd0);
    queue_random(N_RANDOM / 8);
    drain();

    // Random thresholds around the defaults
    for (int k = 0; k < 3; k++) begin
      write_threshold(CFG_HEIGHT_RATIO_MIN, 14'($urandom_range(256, 100)));
      write_threshold(CFG_HEIGHT_RATIO_MAX, 14'($urandom_range(600, 256)));
      write_threshold(CFG_DIRECTION_DIFF_MAX, 14'($urandom_range(16383)));
      write_threshold(CFG_SPACING_RATIO_MIN, 14'($urandom_range(600)));
      write_threshold(CFG_SPACING_RATIO_MAX, 14'($urandom_range(4095, 600)));
      write_threshold(CFG_ALIGNMENT_DEV_MAX, 14'($urandom_range(3000)));
      queue_random(N_RANDOM / 8);
      drain();
    end

    if (n_errors == 0) $display("tb_light_bar_pair_check_top: done, clean");
    else $display("tb_light_bar_pair_check_top: done, errors");
    $finish;
  end
endmodule
